// ----- rtl/core/bdpc_pkg.sv -----
// Shared types and constants for the button debounce and press classifier.
package bdpc_pkg;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd20;
  localparam logic [CFG_W-1:0] HOLD_TICKS_RST       = 16'd1000;
  localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST = 16'd500;

  localparam logic [CFG_W-1:0] PRESS_LEN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_START,
    PH_LOW_STABLE,
    PH_LOW_TEST,
    PH_HIGH_STABLE,
    PH_HIGH_TEST
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_HOLD  = 2'd1,
    EV_SHORT = 2'd2,
    EV_LONG  = 2'd3
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    event_t     press_event;
    logic [2:0] selected_bit;
    logic [7:0] mode_mask;
    logic       stable_level;
  } result_t;

endpackage

// ----- rtl/core/bdpc_if.sv -----
// Valid/ready channel interfaces for the tick input and the result output.
interface bdpc_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface bdpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;
  logic [2:0] selected_bit;
  logic [7:0] mode_mask;
  logic       stable_level;

  modport source (output valid, output press_event, output selected_bit,
                  output mode_mask, output stable_level, input ready);
  modport sink   (input valid, input press_event, input selected_bit,
                  input mode_mask, input stable_level, output ready);
endinterface

// ----- rtl/core/button_debounce_press_classifier.sv -----
// Top level: input register, classifier core, result register and config registers.
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the sink keeps taking results; the result register frees as the sink takes it.
// The state update runs once per item in the cycle it leaves the input register.
// Synchronous active-low reset empties both registers, returns the debouncer to
// its start-up phase and loads the timing registers with 20, 1000 and 500 ticks.
module button_debounce_press_classifier #(
  parameter int unsigned MASK_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bdpc_in_if.sink                             in_ch,
  bdpc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [bdpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bdpc_pkg::CFG_W-1:0]          cfg_wdata
);

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_pin_r;
  logic              out_valid_r, out_valid_nxt;
  bdpc_pkg::result_t out_res_r;
  bdpc_pkg::result_t core_res;
  bdpc_pkg::cfg_t    cfg_r;
  logic              out_free, step, in_accept;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign step      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || step;
  assign in_accept = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  bdpc_core #(
    .MASK_BITS(MASK_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .pin    (s1_pin_r),
    .cfg    (cfg_r),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pin_r <= in_ch.pin_level;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= bdpc_pkg::DEBOUNCE_TICKS_RST;
      cfg_r.hold_ticks       <= bdpc_pkg::HOLD_TICKS_RST;
      cfg_r.long_press_ticks <= bdpc_pkg::LONG_PRESS_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdpc_pkg::CFG_DEBOUNCE_TICKS:   cfg_r.debounce_ticks   <= cfg_wdata;
        bdpc_pkg::CFG_HOLD_TICKS:       cfg_r.hold_ticks       <= cfg_wdata;
        bdpc_pkg::CFG_LONG_PRESS_TICKS: cfg_r.long_press_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.press_event  = out_res_r.press_event;
  assign out_ch.selected_bit = out_res_r.selected_bit;
  assign out_ch.mode_mask    = out_res_r.mode_mask;
  assign out_ch.stable_level = out_res_r.stable_level;

endmodule

// ----- rtl/core/bdpc_core.sv -----
// Debounce state machine, press timer and short/long/hold classification.
module bdpc_core #(
  parameter int unsigned MASK_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              pin,
  input  bdpc_pkg::cfg_t    cfg,
  output bdpc_pkg::result_t result
);

  localparam int unsigned PTR_W = $clog2(MASK_BITS);

  bdpc_pkg::phase_t phase_r, phase_nxt;
  logic                       prev_pin_r;
  logic [bdpc_pkg::CFG_W-1:0] timer_r, timer_nxt;
  logic                       armed_r, armed_nxt;
  logic [bdpc_pkg::CFG_W-1:0] plen_r, plen_nxt, plen_inc;
  logic                       settled_r, settled_nxt;
  logic                       hold_rep_r, hold_rep_nxt;
  logic [PTR_W-1:0]           ptr_r, ptr_nxt;
  logic [MASK_BITS-1:0]       mask_r, mask_nxt;
  logic                       conf_r, conf_nxt;
  bdpc_pkg::event_t           ev;

  logic                       start, restart_hi, restart_lo, restarted, expire;
  logic [bdpc_pkg::CFG_W-1:0] dbt_eff, hold_eff;
  logic [63:0]                ptr_ext, mask_ext;

  assign start      = (phase_r == bdpc_pkg::PH_START);
  assign restart_hi = !start && (pin != prev_pin_r) && pin &&
                      (phase_r == bdpc_pkg::PH_LOW_STABLE);
  assign restart_lo = !start && (pin != prev_pin_r) && !pin &&
                      (phase_r == bdpc_pkg::PH_HIGH_STABLE);
  assign restarted  = start || restart_hi || restart_lo;
  // The timer is always loaded with at least one, so a count of one expires now.
  assign expire     = armed_r && !restarted && (timer_r == 16'd1);

  assign dbt_eff  = (cfg.debounce_ticks == '0) ? 16'd1 : cfg.debounce_ticks;
  assign hold_eff = (cfg.hold_ticks == '0) ? 16'd1 : cfg.hold_ticks;
  assign plen_inc = (plen_r == bdpc_pkg::PRESS_LEN_MAX) ? plen_r : plen_r + 16'd1;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (start) begin
      phase_nxt = pin ? bdpc_pkg::PH_HIGH_TEST : bdpc_pkg::PH_LOW_TEST;
    end else if (restart_hi) begin
      phase_nxt = bdpc_pkg::PH_HIGH_TEST;
    end else if (restart_lo) begin
      phase_nxt = bdpc_pkg::PH_LOW_TEST;
    end else if (expire) begin
      case (phase_r)
        bdpc_pkg::PH_LOW_TEST,
        bdpc_pkg::PH_HIGH_TEST: begin
          phase_nxt = pin ? bdpc_pkg::PH_HIGH_STABLE : bdpc_pkg::PH_LOW_STABLE;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Timer, press bookkeeping and the event of this item.
  always_comb begin
    timer_nxt    = timer_r;
    armed_nxt    = armed_r;
    plen_nxt     = plen_inc;
    settled_nxt  = settled_r;
    hold_rep_nxt = restart_lo ? 1'b0 : hold_rep_r;
    ptr_nxt      = ptr_r;
    mask_nxt     = mask_r;
    conf_nxt     = conf_r;
    ev           = bdpc_pkg::EV_NONE;

    if (restarted) begin
      timer_nxt = dbt_eff;
      armed_nxt = 1'b1;
    end else if (armed_r) begin
      timer_nxt = timer_r - 16'd1;
    end

    if (expire) begin
      armed_nxt = 1'b0;
      case (phase_r)
        bdpc_pkg::PH_LOW_STABLE: begin
          hold_rep_nxt = 1'b1;
          ev           = bdpc_pkg::EV_HOLD;
        end
        bdpc_pkg::PH_LOW_TEST: begin
          conf_nxt = pin;
          if (!pin) begin
            if (settled_r) begin
              plen_nxt  = '0;
              timer_nxt = hold_eff;
              armed_nxt = 1'b1;
            end else begin
              settled_nxt = 1'b1;
            end
          end
        end
        bdpc_pkg::PH_HIGH_TEST: begin
          conf_nxt = pin;
          if (pin) begin
            if (!settled_r) begin
              settled_nxt = 1'b1;
            end else if (!hold_rep_r) begin
              if (plen_inc < cfg.long_press_ticks) begin
                ptr_nxt = (ptr_r == PTR_W'(MASK_BITS - 1)) ? '0 : ptr_r + 1'b1;
                ev      = bdpc_pkg::EV_SHORT;
              end else begin
                mask_nxt = mask_r ^ (MASK_BITS'(1) << ptr_r);
                ev       = bdpc_pkg::EV_LONG;
              end
            end
          end
        end
        default: ev = bdpc_pkg::EV_NONE;
      endcase
    end
  end

  assign ptr_ext  = 64'(ptr_nxt);
  assign mask_ext = 64'(mask_nxt);

  always_comb begin
    result.press_event  = ev;
    result.selected_bit = ptr_ext[2:0];
    result.mode_mask    = mask_ext[7:0];
    result.stable_level = conf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= bdpc_pkg::PH_START;
      prev_pin_r <= 1'b0;
      timer_r    <= '0;
      armed_r    <= 1'b0;
      plen_r     <= '0;
      settled_r  <= 1'b0;
      hold_rep_r <= 1'b0;
      ptr_r      <= '0;
      mask_r     <= '0;
      conf_r     <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      prev_pin_r <= pin;
      timer_r    <= timer_nxt;
      armed_r    <= armed_nxt;
      plen_r     <= plen_nxt;
      settled_r  <= settled_nxt;
      hold_rep_r <= hold_rep_nxt;
      ptr_r      <= ptr_nxt;
      mask_r     <= mask_nxt;
      conf_r     <= conf_nxt;
    end
  end

endmodule

// ----- rtl/core/bdpc_checker.sv -----
// Port-level assertions for the press classifier and their bind to the top level.
module bdpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] press_event,
  input logic [2:0] selected_bit,
  input logic [7:0] mode_mask,
  input logic       stable_level
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A hold is only reported while the confirmed level is pressed.
  a_hold_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (press_event == bdpc_pkg::EV_HOLD) |-> !stable_level)
    else $error("hold event with released level");

  // Short and long presses are classified on a confirmed release.
  a_class_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((press_event == bdpc_pkg::EV_SHORT) ||
                  (press_event == bdpc_pkg::EV_LONG)) |-> stable_level)
    else $error("press classified without a confirmed release");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(press_event) &&
      $stable(selected_bit) && $stable(mode_mask) && $stable(stable_level))
    else $error("stalled result changed");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .press_event  (out_ch.press_event),
  .selected_bit (out_ch.selected_bit),
  .mode_mask    (out_ch.mode_mask),
  .stable_level (out_ch.stable_level)
);

// ----- tb/button_debounce_press_classifier_tb.sv -----
// Self-checking testbench for the button debounce and press classifier.
module button_debounce_press_classifier_tb;

  localparam logic [bdpc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [bdpc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bdpc_pkg::CFG_W-1:0]       cfg_wdata;

  bdpc_in_if  in_ch();
  bdpc_out_if out_ch();

  button_debounce_press_classifier dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Timing settings as the block currently holds them.
  logic [bdpc_pkg::CFG_W-1:0] deb_ticks  = bdpc_pkg::DEBOUNCE_TICKS_RST;
  logic [bdpc_pkg::CFG_W-1:0] hold_ticks = bdpc_pkg::HOLD_TICKS_RST;
  logic [bdpc_pkg::CFG_W-1:0] long_ticks = bdpc_pkg::LONG_PRESS_TICKS_RST;

  // Debouncer state mirrored tick by tick.
  bdpc_pkg::phase_t ph        = bdpc_pkg::PH_START;
  logic             prev_pin  = 1'b0;
  logic [15:0]      tmr       = '0;
  logic             tmr_on    = 1'b0;
  logic [15:0]      press_len = '0;
  logic             settled   = 1'b0;
  logic             hold_seen = 1'b0;
  logic [2:0]       bit_idx   = '0;
  logic [7:0]       mask      = '0;
  logic             level     = 1'b1;

  logic              tick_levels[$];
  bdpc_pkg::result_t predicted_results[$];

  int unsigned total_ticks = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_results   = 0;
  int unsigned fail_count  = 0;
  int unsigned n_settings  = 0;
  int unsigned n_hold      = 0;
  int unsigned n_short     = 0;
  int unsigned n_long      = 0;
  int unsigned send_gap    = 0;
  int unsigned recv_gap    = 0;
  logic        steady      = 1'b0;
  logic        hold_off    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Alternate between stretches with random idling and stretches without any.
  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      steady <= ~steady;
    end
  end

  // Once traffic is flowing, stop taking results long enough for the block to back up.
  initial begin
    wait (n_ticks >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // A zero setting behaves as one tick.
  function automatic void start_timer(input logic [15:0] ticks);
    tmr    = (ticks == 16'd0) ? 16'd1 : ticks;
    tmr_on = 1'b1;
  endfunction

  function automatic bdpc_pkg::result_t classify_tick(input logic pin);
    bdpc_pkg::result_t r;
    bdpc_pkg::event_t  ev;
    logic              restarted;
    ev        = bdpc_pkg::EV_NONE;
    restarted = 1'b0;
    if (press_len != bdpc_pkg::PRESS_LEN_MAX) press_len = press_len + 16'd1;

    // Pin changes first.
    if (ph == bdpc_pkg::PH_START) begin
      prev_pin = pin;
      if (pin) ph = bdpc_pkg::PH_HIGH_TEST;
      else ph = bdpc_pkg::PH_LOW_TEST;
      start_timer(deb_ticks);
      restarted = 1'b1;
    end else if (pin != prev_pin) begin
      if (ph == bdpc_pkg::PH_LOW_STABLE && pin) begin
        ph = bdpc_pkg::PH_HIGH_TEST;
        start_timer(deb_ticks);
        restarted = 1'b1;
      end else if (ph == bdpc_pkg::PH_HIGH_STABLE && !pin) begin
        ph = bdpc_pkg::PH_LOW_TEST;
        start_timer(deb_ticks);
        restarted = 1'b1;
        hold_seen = 1'b0;
      end
      prev_pin = pin;
    end

    // Then the timer, which cannot expire on the tick that restarted it.
    if (tmr_on && !restarted) begin
      tmr = tmr - 16'd1;
      if (tmr == 16'd0) begin
        tmr_on = 1'b0;
        case (ph)
          bdpc_pkg::PH_LOW_STABLE: begin
            hold_seen = 1'b1;
            ev        = bdpc_pkg::EV_HOLD;
          end
          bdpc_pkg::PH_LOW_TEST: begin
            if (!pin) begin
              ph    = bdpc_pkg::PH_LOW_STABLE;
              level = 1'b0;
              if (settled) begin
                press_len = '0;
                start_timer(hold_ticks);
              end else begin
                settled = 1'b1;
              end
            end else begin
              ph    = bdpc_pkg::PH_HIGH_STABLE;
              level = 1'b1;
            end
          end
          bdpc_pkg::PH_HIGH_TEST: begin
            if (pin) begin
              ph    = bdpc_pkg::PH_HIGH_STABLE;
              level = 1'b1;
              if (!settled) begin
                settled = 1'b1;
              end else if (!hold_seen) begin
                if (press_len < long_ticks) begin
                  bit_idx = bit_idx + 3'd1;
                  ev      = bdpc_pkg::EV_SHORT;
                end else begin
                  mask[bit_idx] = ~mask[bit_idx];
                  ev            = bdpc_pkg::EV_LONG;
                end
              end
            end else begin
              ph    = bdpc_pkg::PH_LOW_STABLE;
              level = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end

    r.press_event  = ev;
    r.selected_bit = bit_idx;
    r.mode_mask    = mask;
    r.stable_level = level;
    return r;
  endfunction

  // Sender: offers queued ticks with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.pin_level <= 1'b1;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(classify_tick(in_ch.pin_level));
        n_ticks <= n_ticks + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (tick_levels.size() > 0) begin
          in_ch.valid     <= 1'b1;
          in_ch.pin_level <= tick_levels.pop_front();
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result against the oldest prediction.
  always @(posedge clk) begin
    bdpc_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"result %0d arrived with nothing predicted: ",
                      "event %0d bit %0d mask %02h level %0b"},
                     n_results, out_ch.press_event, out_ch.selected_bit,
                     out_ch.mode_mask, out_ch.stable_level);
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.press_event !== want.press_event ||
              out_ch.selected_bit !== want.selected_bit ||
              out_ch.mode_mask !== want.mode_mask ||
              out_ch.stable_level !== want.stable_level) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result %0d: expected event %0d bit %0d mask %02h level %0b, ",
                        "got event %0d bit %0d mask %02h level %0b"},
                       n_results, want.press_event, want.selected_bit, want.mode_mask,
                       want.stable_level, out_ch.press_event, out_ch.selected_bit,
                       out_ch.mode_mask, out_ch.stable_level);
          end
          case (want.press_event)
            bdpc_pkg::EV_HOLD:  n_hold++;
            bdpc_pkg::EV_SHORT: n_short++;
            bdpc_pkg::EV_LONG:  n_long++;
            default: ;
          endcase
        end
        n_results++;
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [bdpc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bdpc_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bdpc_pkg::CFG_DEBOUNCE_TICKS:   deb_ticks  = val;
      bdpc_pkg::CFG_HOLD_TICKS:       hold_ticks = val;
      bdpc_pkg::CFG_LONG_PRESS_TICKS: long_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [bdpc_pkg::CFG_W-1:0] deb,
                            input logic [bdpc_pkg::CFG_W-1:0] hold,
                            input logic [bdpc_pkg::CFG_W-1:0] long_press);
    write_reg(bdpc_pkg::CFG_DEBOUNCE_TICKS, deb);
    write_reg(bdpc_pkg::CFG_HOLD_TICKS, hold);
    write_reg(bdpc_pkg::CFG_LONG_PRESS_TICKS, long_press);
    n_settings++;
  endtask

  task automatic push_run(input logic lvl, input int unsigned n);
    repeat (n) begin
      tick_levels.push_back(lvl);
      total_ticks++;
    end
  endtask

  task automatic push_chatter(input int unsigned n);
    repeat (n) begin
      tick_levels.push_back(1'($urandom));
      total_ticks++;
    end
  endtask

  // Mostly clean presses and releases sized around the current settings, some with
  // contact bounce, plus pure noise.
  task automatic push_presses(input int unsigned n);
    int unsigned first;
    int unsigned r;
    int unsigned span;
    first = total_ticks;
    while (total_ticks - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        push_chatter($urandom_range(1, 8));
      end else begin
        if (r < 40) push_chatter($urandom_range(1, 3));
        span = 2 * deb_ticks + hold_ticks + 4;
        push_run(1'b0, $urandom_range(1, span));
        if (r < 50) push_chatter($urandom_range(1, 3));
        push_run(1'b1, $urandom_range(1, 2 * deb_ticks + 10));
      end
    end
  endtask

  task automatic wait_for_results();
    do @(posedge clk);
    while (n_ticks != total_ticks || predicted_results.size() != 0);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timing: the very first tick is pressed, so start-up settles on a press.
    // Bounces right after the release are ignored while the level is under test.
    push_run(1'b0, 22);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 20);
    wait_for_results();

    // Short timing: a short press, a long press, then a press held into the hold event.
    set_timing(16'd1, 16'd5, 16'd3);
    write_reg(CFG_SPARE_INDEX, 16'hFFFF);
    push_run(1'b0, 2);
    push_run(1'b1, 2);
    push_run(1'b0, 3);
    push_run(1'b1, 2);
    push_run(1'b0, 8);
    push_run(1'b1, 2);
    wait_for_results();

    // All zero settings act as single-tick timers.
    set_timing(16'd0, 16'd0, 16'd0);
    push_presses(60);
    wait_for_results();

    for (int p = 0; p < 5; p++) begin
      set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 40)),
                 16'($urandom_range(1, 30)));
      if (p == 2) write_reg(CFG_SPARE_INDEX, 16'($urandom));
      push_presses(130);
      wait_for_results();
    end

    // Leave the block released and stable before the maximum settings.
    push_run(1'b1, 20);
    wait_for_results();

    // Maximum settings: a short press never outlasts the debounce time, so every
    // result keeps the last confirmed state.
    set_timing(bdpc_pkg::PRESS_LEN_MAX, bdpc_pkg::PRESS_LEN_MAX, bdpc_pkg::PRESS_LEN_MAX);
    push_run(1'b0, 30);
    push_run(1'b1, 10);
    wait_for_results();

    repeat (10) @(posedge clk);
    $display({"Sent %0d ticks under %0d timing settings, ",
              "from single-tick timers up to the largest register values."},
             total_ticks, n_settings);
    $display("Checked %0d results: %0d hold, %0d short and %0d long press events, %0d failures.",
             n_results, n_hold, n_short, n_long, fail_count);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
